@@ src/lskt_pkg.sv @@
package lskt_pkg;

	localparam int ENTRIES     = 64;
	localparam int HANDLE_BITS = 32;
	localparam int AW          = $clog2(ENTRIES);
	localparam int IW          = $clog2(ENTRIES + 1);
	localparam int SND_W       = 16;
	localparam int LIM_W       = 16;

	typedef logic [HANDLE_BITS-1:0] handle_t;

	typedef enum logic [2:0] {
		FN_ADD        = 3'd0,
		FN_KEEP_ALIVE = 3'd1,
		FN_REM_PAIR   = 3'd2,
		FN_REM_OBJECT = 3'd3,
		FN_MARK_STOP  = 3'd4,
		FN_SWEEP      = 3'd5,
		FN_CLEAR      = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_STOP   = 2'd1,
		ACT_ENSURE = 2'd2
	} act_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_SHIFT_RD,
		ST_SHIFT_EV,
		ST_PACK_RD,
		ST_PACK_EV,
		ST_APPEND,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		W_NONE,
		W_REFRESH,
		W_STOP,
		W_UNSEEN,
		W_COPY_IDX,
		W_COPY_WR,
		W_NEW_IDLE,
		W_NEW_LIVE
	} wr_op_t;

	typedef struct packed {
		logic [2:0]       func;
		logic [31:0]      object_handle;
		logic [SND_W-1:0] sound_id;
		logic [LIM_W-1:0] same_id_limit;
	} req_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [31:0]      cmd_object;
		logic [SND_W-1:0] cmd_sound;
		logic             last;
	} res_t;

	typedef struct packed {
		handle_t          obj;
		logic [SND_W-1:0] snd;
		logic             alive;
		logic             seen;
		logic             stop;
	} entry_t;

	typedef struct packed {
		logic   load;
		logic   idx_up0;
		logic   idx_down0;
		logic   step_up;
		logic   step_down;
		logic   rd_next;
		logic   wr_clr;
		logic   wr_inc;
		logic   same_clr;
		logic   same_inc;
		logic   cnt_inc;
		logic   cnt_dec;
		logic   cnt_clr;
		logic   cnt_kept;
		logic   push;
		act_t   push_act;
		logic   push_entry;
		logic   flush;
		wr_op_t wr_op;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       empty;
		logic       full;
		logic       up_last;
		logic       down_last;
		logic       last_move;
		logic       pair_hit;
		logic       obj_hit;
		logic       snd_hit;
		logic       obj_zero;
		logic       drop;
		logic       kept;
		logic       same_ok;
		logic       lim_zero;
	} stat_t;

endpackage

@@ src/lskt_ctrl.sv @@
module lskt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lskt_pkg::stat_t st,
	output lskt_pkg::cmd_t  cmd
);

	lskt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lskt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != lskt_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.push_act = lskt_pkg::ACT_START;
		cmd.wr_op = lskt_pkg::W_NONE;
		unique case (state_q)
			lskt_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = lskt_pkg::ST_DISPATCH;
				end
			end
			lskt_pkg::ST_DISPATCH: begin
				state_d = lskt_pkg::ST_FINISH;
				unique case (st.func)
					lskt_pkg::FN_ADD, lskt_pkg::FN_KEEP_ALIVE: begin
						cmd.same_clr = 1'b1;
						cmd.idx_up0 = 1'b1;
						state_d = st.empty ? lskt_pkg::ST_APPEND : lskt_pkg::ST_SCAN_RD;
					end
					lskt_pkg::FN_REM_PAIR, lskt_pkg::FN_REM_OBJECT: begin
						cmd.idx_down0 = 1'b1;
						if (!st.empty) state_d = lskt_pkg::ST_SCAN_RD;
					end
					lskt_pkg::FN_MARK_STOP: begin
						cmd.idx_up0 = 1'b1;
						if (!st.empty && !st.obj_zero) state_d = lskt_pkg::ST_SCAN_RD;
					end
					lskt_pkg::FN_SWEEP: begin
						cmd.same_clr = 1'b1;
						cmd.idx_down0 = 1'b1;
						if (!st.empty) state_d = lskt_pkg::ST_SCAN_RD;
					end
					lskt_pkg::FN_CLEAR: begin
						cmd.cnt_clr = 1'b1;
					end
					default: begin
					end
				endcase
			end
			lskt_pkg::ST_SCAN_RD: begin
				state_d = lskt_pkg::ST_SCAN_EV;
			end
			lskt_pkg::ST_SCAN_EV: begin
				state_d = lskt_pkg::ST_FINISH;
				unique case (st.func)
					lskt_pkg::FN_ADD: begin
						if (!st.pair_hit) begin
							if (st.up_last) begin
								state_d = lskt_pkg::ST_APPEND;
							end else begin
								cmd.step_up = 1'b1;
								state_d = lskt_pkg::ST_SCAN_RD;
							end
						end
					end
					lskt_pkg::FN_KEEP_ALIVE: begin
						cmd.same_inc = st.snd_hit && !st.lim_zero;
						if (st.pair_hit) begin
							cmd.wr_op = lskt_pkg::W_REFRESH;
						end else if (st.up_last) begin
							state_d = lskt_pkg::ST_APPEND;
						end else begin
							cmd.step_up = 1'b1;
							state_d = lskt_pkg::ST_SCAN_RD;
						end
					end
					lskt_pkg::FN_REM_PAIR, lskt_pkg::FN_REM_OBJECT: begin
						if ((st.func == lskt_pkg::FN_REM_PAIR) ? st.pair_hit : st.obj_hit) begin
							cmd.push = 1'b1;
							cmd.push_act = lskt_pkg::ACT_STOP;
							cmd.push_entry = 1'b1;
							if (st.up_last) begin
								cmd.cnt_dec = 1'b1;
							end else begin
								state_d = lskt_pkg::ST_SHIFT_RD;
							end
						end else if (!st.down_last) begin
							cmd.step_down = 1'b1;
							state_d = lskt_pkg::ST_SCAN_RD;
						end
					end
					lskt_pkg::FN_MARK_STOP: begin
						if (st.obj_hit) cmd.wr_op = lskt_pkg::W_STOP;
						if (!st.up_last) begin
							cmd.step_up = 1'b1;
							state_d = lskt_pkg::ST_SCAN_RD;
						end
					end
					lskt_pkg::FN_SWEEP: begin
						if (st.drop) begin
							cmd.push = 1'b1;
							cmd.push_act = lskt_pkg::ACT_STOP;
							cmd.push_entry = 1'b1;
							cmd.wr_op = lskt_pkg::W_STOP;
						end else begin
							cmd.wr_op = lskt_pkg::W_UNSEEN;
							cmd.same_inc = 1'b1;
						end
						if (st.down_last) begin
							cmd.idx_up0 = 1'b1;
							cmd.wr_clr = 1'b1;
							state_d = lskt_pkg::ST_PACK_RD;
						end else begin
							cmd.step_down = 1'b1;
							state_d = lskt_pkg::ST_SCAN_RD;
						end
					end
					default: begin
					end
				endcase
			end
			lskt_pkg::ST_SHIFT_RD: begin
				cmd.rd_next = 1'b1;
				state_d = lskt_pkg::ST_SHIFT_EV;
			end
			lskt_pkg::ST_SHIFT_EV: begin
				cmd.wr_op = lskt_pkg::W_COPY_IDX;
				if (st.last_move) begin
					cmd.cnt_dec = 1'b1;
					state_d = lskt_pkg::ST_FINISH;
				end else begin
					cmd.step_up = 1'b1;
					state_d = lskt_pkg::ST_SHIFT_RD;
				end
			end
			lskt_pkg::ST_PACK_RD: begin
				state_d = lskt_pkg::ST_PACK_EV;
			end
			lskt_pkg::ST_PACK_EV: begin
				// Entries that survived the sweep move down to close the gaps.
				if (st.kept) begin
					cmd.wr_op = lskt_pkg::W_COPY_WR;
					cmd.wr_inc = 1'b1;
					cmd.push = 1'b1;
					cmd.push_act = lskt_pkg::ACT_ENSURE;
					cmd.push_entry = 1'b1;
				end
				if (st.up_last) begin
					cmd.cnt_kept = 1'b1;
					state_d = lskt_pkg::ST_FINISH;
				end else begin
					cmd.step_up = 1'b1;
					state_d = lskt_pkg::ST_PACK_RD;
				end
			end
			lskt_pkg::ST_APPEND: begin
				state_d = lskt_pkg::ST_FINISH;
				if (!st.full) begin
					if (st.func == lskt_pkg::FN_ADD) begin
						cmd.wr_op = lskt_pkg::W_NEW_IDLE;
						cmd.cnt_inc = 1'b1;
						cmd.push = 1'b1;
					end else if (st.same_ok) begin
						cmd.wr_op = lskt_pkg::W_NEW_LIVE;
						cmd.cnt_inc = 1'b1;
						cmd.push = 1'b1;
					end
				end
			end
			lskt_pkg::ST_FINISH: begin
				cmd.flush = 1'b1;
				state_d = lskt_pkg::ST_IDLE;
			end
			default: begin
				state_d = lskt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/lskt_dp.sv @@
module lskt_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  lskt_pkg::req_t  request,
	input  lskt_pkg::cmd_t  cmd,
	output lskt_pkg::stat_t st,
	output lskt_pkg::res_t  result,
	output logic            result_strobe
);

	lskt_pkg::entry_t mem [lskt_pkg::ENTRIES];
	lskt_pkg::entry_t rdata_q;
	lskt_pkg::entry_t wdata;
	logic [lskt_pkg::AW-1:0] raddr;
	logic [lskt_pkg::AW-1:0] waddr;
	logic                    we;

	logic [2:0]                 func_q;
	lskt_pkg::handle_t          obj_q;
	logic [lskt_pkg::SND_W-1:0] snd_q;
	logic [lskt_pkg::LIM_W-1:0] lim_q;
	logic [lskt_pkg::IW-1:0]    cnt_q;
	logic [lskt_pkg::IW-1:0]    idx_q;
	logic [lskt_pkg::IW-1:0]    wr_q;
	logic [lskt_pkg::IW-1:0]    same_q;

	// One result is held back so that the final one can carry last.
	logic                        pend_v_q;
	logic [1:0]                  pend_act_q;
	lskt_pkg::handle_t           pend_obj_q;
	logic [lskt_pkg::SND_W-1:0]  pend_snd_q;
	lskt_pkg::res_t              out_q;
	logic                        strobe_q;
	lskt_pkg::handle_t           push_obj;
	logic [lskt_pkg::SND_W-1:0]  push_snd;

	assign raddr = cmd.rd_next ? lskt_pkg::AW'(idx_q + 1'b1) : idx_q[lskt_pkg::AW-1:0];

	always_comb begin
		we = 1'b1;
		wdata = rdata_q;
		waddr = idx_q[lskt_pkg::AW-1:0];
		unique case (cmd.wr_op)
			lskt_pkg::W_NONE:     we = 1'b0;
			lskt_pkg::W_REFRESH: begin
				wdata.alive = 1'b1;
				wdata.seen = 1'b1;
			end
			lskt_pkg::W_STOP:     wdata.stop = 1'b1;
			lskt_pkg::W_UNSEEN:   wdata.seen = 1'b0;
			lskt_pkg::W_COPY_IDX: wdata = rdata_q;
			lskt_pkg::W_COPY_WR:  waddr = wr_q[lskt_pkg::AW-1:0];
			lskt_pkg::W_NEW_IDLE, lskt_pkg::W_NEW_LIVE: begin
				waddr = cnt_q[lskt_pkg::AW-1:0];
				wdata.obj = obj_q;
				wdata.snd = snd_q;
				wdata.alive = (cmd.wr_op == lskt_pkg::W_NEW_LIVE);
				wdata.seen = (cmd.wr_op == lskt_pkg::W_NEW_LIVE);
				wdata.stop = 1'b0;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= request.func;
			obj_q <= lskt_pkg::HANDLE_BITS'(request.object_handle);
			snd_q <= request.sound_id;
			lim_q <= request.same_id_limit;
		end
		if (cmd.idx_up0) idx_q <= '0;
		else if (cmd.idx_down0) idx_q <= cnt_q - 1'b1;
		else if (cmd.step_up) idx_q <= idx_q + 1'b1;
		else if (cmd.step_down) idx_q <= idx_q - 1'b1;
		if (cmd.wr_clr) wr_q <= '0;
		else if (cmd.wr_inc) wr_q <= wr_q + 1'b1;
		if (cmd.same_clr) same_q <= '0;
		else if (cmd.same_inc) same_q <= same_q + 1'b1;
		if (cmd.push) begin
			pend_act_q <= cmd.push_act;
			pend_obj_q <= push_obj;
			pend_snd_q <= push_snd;
		end
		out_q.action <= pend_act_q;
		out_q.cmd_object <= 32'(pend_obj_q);
		out_q.cmd_sound <= pend_snd_q;
		out_q.last <= cmd.flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
			else if (cmd.cnt_dec) cnt_q <= cnt_q - 1'b1;
			else if (cmd.cnt_kept) cnt_q <= same_q;
			strobe_q <= pend_v_q && (cmd.push || cmd.flush);
			if (cmd.push) pend_v_q <= 1'b1;
			else if (cmd.flush) pend_v_q <= 1'b0;
		end
	end

	assign push_obj = cmd.push_entry ? rdata_q.obj : obj_q;
	assign push_snd = cmd.push_entry ? rdata_q.snd : snd_q;

	assign result = out_q;
	assign result_strobe = strobe_q;

	assign st.func      = func_q;
	assign st.empty     = (cnt_q == '0);
	assign st.full      = (cnt_q == lskt_pkg::IW'(lskt_pkg::ENTRIES));
	assign st.up_last   = (lskt_pkg::IW'(idx_q + 1'b1) == cnt_q);
	assign st.down_last = (idx_q == '0);
	assign st.last_move = ((lskt_pkg::IW+1)'(idx_q) + 2'd2 == (lskt_pkg::IW+1)'(cnt_q));
	assign st.obj_hit   = (rdata_q.obj == obj_q);
	assign st.snd_hit   = (rdata_q.snd == snd_q);
	assign st.pair_hit  = st.obj_hit && st.snd_hit;
	assign st.obj_zero  = (obj_q == '0);
	assign st.drop      = rdata_q.stop || (rdata_q.alive && !rdata_q.seen);
	assign st.kept      = !rdata_q.stop;
	assign st.same_ok   = (lskt_pkg::LIM_W'(same_q) <= lim_q);
	assign st.lim_zero  = (lim_q == '0);

endmodule

@@ src/looped_sound_keepalive_table.sv @@
// Channel   Handshake                 Payload
// request   start in, busy out        lskt_pkg::req_t
// result    result_strobe out         lskt_pkg::res_t
//
// Every entry read goes through the single registered read port of the entry
// memory, so an item reads each table entry it visits in turn. A removal also
// shifts the later entries down one by one; a sweep walks the table twice.
// Reset clears the entry count; entry contents need no clearing pass.
// Results appear one cycle each on result_strobe; the receiver cannot stall.
module looped_sound_keepalive_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lskt_pkg::req_t request,
	output lskt_pkg::res_t result,
	output logic           result_strobe
);

	lskt_pkg::cmd_t  cmd;
	lskt_pkg::stat_t st;

	lskt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	lskt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.request       (request),
		.cmd           (cmd),
		.st            (st),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

@@ src/lskt_checker.sv @@
module lskt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input lskt_pkg::req_t request,
	input lskt_pkg::res_t result,
	input logic           result_strobe
);

	// An accepted item always raises busy in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// More results are still owed, so the block cannot be idle.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |-> busy)
		else $error("non-final result while idle");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.action == lskt_pkg::ACT_START ||
			result.action == lskt_pkg::ACT_STOP ||
			result.action == lskt_pkg::ACT_ENSURE))
		else $error("unknown action code");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |=> !result_strobe)
		else $error("result directly after a final result");

endmodule

bind looped_sound_keepalive_table lskt_checker u_lskt_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

class sound_table_scoreboard;
	lskt_pkg::handle_t tbl_obj[$];
	logic [15:0]       tbl_snd[$];
	bit                tbl_alive[$];
	bit                tbl_seen[$];
	bit                tbl_stop[$];
	lskt_pkg::res_t    pending_cmds[$];
	int                errors;

	function void reset_table();
		tbl_obj.delete();
		tbl_snd.delete();
		tbl_alive.delete();
		tbl_seen.delete();
		tbl_stop.delete();
	endfunction

	function void drop_at(int i);
		tbl_obj.delete(i);
		tbl_snd.delete(i);
		tbl_alive.delete(i);
		tbl_seen.delete(i);
		tbl_stop.delete(i);
	endfunction

	function bit push_entry(lskt_pkg::handle_t o, logic [15:0] s, bit live);
		if (tbl_obj.size() >= lskt_pkg::ENTRIES)
			return 0;
		tbl_obj.push_back(o);
		tbl_snd.push_back(s);
		tbl_alive.push_back(live);
		tbl_seen.push_back(live);
		tbl_stop.push_back(0);
		return 1;
	endfunction

	function void queue_cmd(lskt_pkg::act_t a, lskt_pkg::handle_t o, logic [15:0] s);
		lskt_pkg::res_t r;
		r.action = a;
		r.cmd_object = o;
		r.cmd_sound = s;
		r.last = 0;
		pending_cmds.push_back(r);
	endfunction

	function void note_item(lskt_pkg::req_t q);
		int n0, same;
		bit done;
		n0 = pending_cmds.size();
		done = 0;
		case (q.func)
		lskt_pkg::FN_ADD: begin
			for (int k = 0; k < tbl_obj.size(); k++)
				if (tbl_obj[k] == q.object_handle && tbl_snd[k] == q.sound_id)
					done = 1;
			if (!done && push_entry(q.object_handle, q.sound_id, 0))
				queue_cmd(lskt_pkg::ACT_START, q.object_handle, q.sound_id);
		end
		lskt_pkg::FN_KEEP_ALIVE: begin
			same = 0;
			for (int k = 0; k < tbl_obj.size() && !done; k++) begin
				if (tbl_snd[k] == q.sound_id) begin
					if (q.same_id_limit != 0)
						same++;
					if (tbl_obj[k] == q.object_handle) begin
						tbl_alive[k] = 1;
						tbl_seen[k] = 1;
						done = 1;
					end
				end
			end
			if (!done && same <= q.same_id_limit
					&& push_entry(q.object_handle, q.sound_id, 1))
				queue_cmd(lskt_pkg::ACT_START, q.object_handle, q.sound_id);
		end
		lskt_pkg::FN_REM_PAIR: begin
			for (int k = tbl_obj.size() - 1; k >= 0 && !done; k--)
				if (tbl_obj[k] == q.object_handle && tbl_snd[k] == q.sound_id) begin
					drop_at(k);
					queue_cmd(lskt_pkg::ACT_STOP, q.object_handle, q.sound_id);
					done = 1;
				end
		end
		lskt_pkg::FN_REM_OBJECT: begin
			for (int k = tbl_obj.size() - 1; k >= 0 && !done; k--)
				if (tbl_obj[k] == q.object_handle) begin
					queue_cmd(lskt_pkg::ACT_STOP, q.object_handle, tbl_snd[k]);
					drop_at(k);
					done = 1;
				end
		end
		lskt_pkg::FN_MARK_STOP: begin
			if (q.object_handle != 0)
				for (int k = 0; k < tbl_obj.size(); k++)
					if (tbl_obj[k] == q.object_handle)
						tbl_stop[k] = 1;
		end
		lskt_pkg::FN_SWEEP: begin
			for (int k = tbl_obj.size() - 1; k >= 0; k--) begin
				if (tbl_stop[k] || (tbl_alive[k] && !tbl_seen[k])) begin
					queue_cmd(lskt_pkg::ACT_STOP, tbl_obj[k], tbl_snd[k]);
					drop_at(k);
				end else begin
					tbl_seen[k] = 0;
				end
			end
			for (int k = 0; k < tbl_obj.size(); k++)
				queue_cmd(lskt_pkg::ACT_ENSURE, tbl_obj[k], tbl_snd[k]);
		end
		lskt_pkg::FN_CLEAR: reset_table();
		default: ;
		endcase
		if (pending_cmds.size() > n0)
			pending_cmds[pending_cmds.size() - 1].last = 1;
	endfunction

	task report(string msg);
		$display("ERROR %0t: %s", $time, msg);
		errors++;
	endtask

	task check_cmd(lskt_pkg::res_t r);
		lskt_pkg::res_t e;
		if (pending_cmds.size() == 0) begin
			report($sformatf("unexpected command %p", r));
			return;
		end
		e = pending_cmds.pop_front();
		if (r.action != e.action)
			report($sformatf("action %0d, want %0d", r.action, e.action));
		if (r.cmd_object != e.cmd_object)
			report($sformatf("object %h, want %h", r.cmd_object, e.cmd_object));
		if (r.cmd_sound != e.cmd_sound)
			report($sformatf("sound %h, want %h", r.cmd_sound, e.cmd_sound));
		if (r.last != e.last)
			report($sformatf("last %0d, want %0d", r.last, e.last));
	endtask
endclass

module testbench;
	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	lskt_pkg::req_t request = '0;
	lskt_pkg::res_t result;
	logic result_strobe;
	int   idle_pct = 0;

	sound_table_scoreboard sb = new();

	looped_sound_keepalive_table i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result(result), .result_strobe(result_strobe)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			sb.check_cmd(result);
	end

	// Small pools make pairs repeat, so matches and refreshes are common.
	lskt_pkg::handle_t obj_pool[4] = '{32'h1, 32'hFFFF_FFFF, 32'h8000_0001, 32'h5A5A_A5A5};
	logic [15:0]       snd_pool[3] = '{16'h0, 16'hFFFF, 16'h1234};

	task automatic send_item(logic [2:0] fn, lskt_pkg::handle_t o, logic [15:0] s,
			logic [15:0] lim);
		lskt_pkg::req_t q;
		while ($urandom_range(99) < idle_pct)
			@(posedge clk);
		q.func = fn;
		q.object_handle = o;
		q.sound_id = s;
		q.same_id_limit = lim;
		request <= q;
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_item(q);
		start <= 0;
		// The block is busy right after an accepted item, so nothing is lost here.
		@(posedge clk);
	endtask

	task automatic random_item();
		int r;
		lskt_pkg::handle_t o;
		logic [15:0] s;
		logic [15:0] lim;
		r = $urandom_range(99);
		o = ($urandom_range(9) == 0) ? lskt_pkg::handle_t'($urandom)
			: obj_pool[$urandom_range(3)];
		if ($urandom_range(19) == 0)
			o = 0;
		s = ($urandom_range(9) == 0) ? 16'($urandom) : snd_pool[$urandom_range(2)];
		lim = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
		if (r < 30)
			send_item(lskt_pkg::FN_KEEP_ALIVE, o, s, lim);
		else if (r < 50)
			send_item(lskt_pkg::FN_ADD, o, s, 16'($urandom));
		else if (r < 62)
			send_item(lskt_pkg::FN_REM_PAIR, o, s, 16'($urandom));
		else if (r < 72)
			send_item(lskt_pkg::FN_REM_OBJECT, o, s, 16'($urandom));
		else if (r < 82)
			send_item(lskt_pkg::FN_MARK_STOP, o, s, 16'($urandom));
		else if (r < 96)
			send_item(lskt_pkg::FN_SWEEP, o, s, 16'($urandom));
		else if (r < 98)
			send_item(lskt_pkg::FN_CLEAR, o, s, 16'($urandom));
		else
			send_item(3'd7, o, s, lim);
	endtask

	initial begin
		int pct[4] = '{0, 68, 0, 33};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: every operation, extremes and the special cases.
		send_item(lskt_pkg::FN_SWEEP, 0, 0, 0);
		send_item(lskt_pkg::FN_REM_PAIR, 1, 1, 0);
		send_item(lskt_pkg::FN_REM_OBJECT, 1, 0, 0);
		send_item(lskt_pkg::FN_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_item(lskt_pkg::FN_ADD, 32'hFFFF_FFFF, 16'hFFFF, 0);
		send_item(lskt_pkg::FN_ADD, 0, 0, 0);
		send_item(lskt_pkg::FN_KEEP_ALIVE, 32'h1, 16'hFFFF, 16'd1);
		send_item(lskt_pkg::FN_KEEP_ALIVE, 32'h2, 16'hFFFF, 16'd1);
		send_item(lskt_pkg::FN_KEEP_ALIVE, 32'h3, 16'hFFFF, 16'd0);
		send_item(lskt_pkg::FN_KEEP_ALIVE, 32'h1, 16'hFFFF, 16'hFFFF);
		send_item(lskt_pkg::FN_MARK_STOP, 0, 0, 0);
		send_item(lskt_pkg::FN_MARK_STOP, 32'h3, 0, 0);
		send_item(3'd7, 32'h1, 16'h1, 16'h1);
		send_item(lskt_pkg::FN_SWEEP, 0, 0, 0);
		send_item(lskt_pkg::FN_SWEEP, 0, 0, 0);
		send_item(lskt_pkg::FN_REM_PAIR, 32'hFFFF_FFFF, 16'hFFFF, 0);
		send_item(lskt_pkg::FN_REM_OBJECT, 0, 0, 0);
		// Fill past capacity so appends get dropped.
		for (int k = 0; k < lskt_pkg::ENTRIES + 2; k++)
			send_item(lskt_pkg::FN_ADD, lskt_pkg::handle_t'(k + 100), 16'(k), 0);
		send_item(lskt_pkg::FN_KEEP_ALIVE, 32'h7, 16'h7, 0);
		send_item(lskt_pkg::FN_SWEEP, 0, 0, 0);
		send_item(lskt_pkg::FN_CLEAR, 0, 0, 0);

		for (int p = 0; p < 4; p++) begin
			idle_pct = pct[p];
			for (int i = 0; i < 70; i++)
				random_item();
		end

		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
src/lskt_pkg.sv
src/lskt_ctrl.sv
src/lskt_dp.sv
src/looped_sound_keepalive_table.sv
src/lskt_checker.sv
bench/testbench.sv
